/* src/hta_pkg.sv */
// ----------------------------------------------------------------------------
// hta_pkg
// Shared widths, opcodes and defaults for the handle table allocator.
// ----------------------------------------------------------------------------
package hta_pkg;

  localparam int OP_W     = 2;
  localparam int SLOT_W   = 5;
  localparam int HANDLE_W = 16;

  // Number of slots the slot field can name.
  localparam int SLOT_SPACE = 1 << SLOT_W;

  // Slots that come out of reset open, each holding its own index as handle.
  localparam int PRESET_SLOTS = 3;

  localparam int TABLE_SIZE_DEF = 32;

  localparam logic [OP_W-1:0] OP_OPEN   = 2'd0;
  localparam logic [OP_W-1:0] OP_CLOSE  = 2'd1;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

endpackage

/* src/hta_ram.sv */
// ----------------------------------------------------------------------------
// hta_ram
// Generic simple dual-port RAM with one write port and a registered read port.
// ----------------------------------------------------------------------------
module hta_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* src/handle_table_allocator.sv */
// ----------------------------------------------------------------------------
// handle_table_allocator
// Slot table mapping small slot numbers to host handles, with a free bitmap.
// ----------------------------------------------------------------------------
// Requests arrive on the req channel (opcode, slot, host_handle) and each one
// produces exactly one response on the rsp channel (ok, slot_out, handle_out,
// is_open). Both channels use valid/stall; a transfer happens on a clock edge
// with valid high and stall low.
// The occupancy bitmap lives in flip-flops and is searched for the lowest
// free slot by a priority encoder in the cycle a request is taken, so the
// bitmap is current for the very next request. Host handles live in a RAM
// with a registered read; a close or lookup reads it at transfer
// and the handle joins the response in the following stage.
// A request passes through the middle stage into the output register, which
// raises response valid, and one request per cycle is sustained while the
// receiver keeps up.
// When the receiver stalls, the output register holds its response, the
// middle stage holds one more, and then req_stall rises.
// Synchronous reset opens slots 0 to 2 with handles 0 to 2 and frees all
// others; the bitmap and preset flags load directly, with no clearing pass.
// ----------------------------------------------------------------------------
module handle_table_allocator #(
  parameter int TABLE_SIZE = hta_pkg::TABLE_SIZE_DEF
) (
  input  logic                         clk,
  input  logic                         rst,

  input  logic                         req_valid,
  output logic                         req_stall,
  input  logic [hta_pkg::OP_W-1:0]     opcode,
  input  logic [hta_pkg::SLOT_W-1:0]   slot,
  input  logic [hta_pkg::HANDLE_W-1:0] host_handle,

  output logic                         rsp_valid,
  input  logic                         rsp_stall,
  output logic                         ok,
  output logic [hta_pkg::SLOT_W-1:0]   slot_out,
  output logic [hta_pkg::HANDLE_W-1:0] handle_out,
  output logic                         is_open
);

  // Only the slots that the slot field can name are ever tracked.
  localparam int MAP_W = (TABLE_SIZE < hta_pkg::SLOT_SPACE) ? TABLE_SIZE
                                                            : hta_pkg::SLOT_SPACE;
  localparam int MW    = $clog2(MAP_W);
  localparam int AW    = $clog2(TABLE_SIZE);
  localparam int PW    = $clog2(hta_pkg::PRESET_SLOTS);
  localparam logic [MAP_W-1:0] MAP_RESET = MAP_W'((1 << hta_pkg::PRESET_SLOTS) - 1);

  typedef struct packed {
    logic                       ok;
    logic [hta_pkg::SLOT_W-1:0] slot;
    logic                       is_open;
    logic                       want_handle;
    logic                       use_preset;
    logic [PW-1:0]              preset_val;
  } stage_t;

  logic [MAP_W-1:0]               open_map;
  logic [hta_pkg::PRESET_SLOTS-1:0] preset_live;

  logic                           s1_valid;
  stage_t                         s1;
  stage_t                         s1_next;

  logic                           req_xfer;
  logic                           s1_adv;

  logic                           free_found;
  logic [MW-1:0]                  free_idx;
  logic                           slot_in_map;
  logic                           slot_open;
  logic                           slot_preset;
  logic [AW+hta_pkg::SLOT_W-1:0]  slot_wide;
  logic [AW-1:0]                  rd_addr;
  logic                           rd_en;
  logic                           wr_en;
  logic [hta_pkg::HANDLE_W-1:0]   ram_data;

  assign req_stall = s1_valid && rsp_valid && rsp_stall;
  assign req_xfer  = req_valid && !req_stall;
  assign s1_adv    = s1_valid && !(rsp_valid && rsp_stall);

  // Lowest free slot. Scanning from the top lets the lowest index win.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = MAP_W - 1; i >= 0; i--) begin
      if (!open_map[i]) begin
        free_found = 1'b1;
        free_idx   = MW'(i);
      end
    end
  end

  assign slot_in_map = ({1'b0, slot} < (hta_pkg::SLOT_W + 1)'(MAP_W));
  assign slot_open   = slot_in_map && open_map[slot[MW-1:0]];
  assign slot_preset = ({1'b0, slot} < (hta_pkg::SLOT_W + 1)'(hta_pkg::PRESET_SLOTS))
                       && preset_live[slot[PW-1:0]];

  assign slot_wide = (AW + hta_pkg::SLOT_W)'(slot);
  assign rd_addr   = slot_wide[AW-1:0];

  always_comb begin
    s1_next             = '0;
    s1_next.slot        = slot;
    s1_next.use_preset  = slot_preset;
    s1_next.preset_val  = slot[PW-1:0];
    rd_en               = 1'b0;
    wr_en               = 1'b0;
    case (opcode)
      hta_pkg::OP_OPEN: begin
        s1_next.ok      = free_found;
        s1_next.is_open = free_found;
        s1_next.slot    = free_found ? hta_pkg::SLOT_W'(free_idx) : '0;
        wr_en           = req_xfer && free_found;
      end
      hta_pkg::OP_CLOSE: begin
        s1_next.ok          = slot_open;
        s1_next.want_handle = slot_open;
        rd_en               = req_xfer;
      end
      hta_pkg::OP_LOOKUP: begin
        s1_next.ok          = slot_open;
        s1_next.is_open     = slot_open;
        s1_next.want_handle = slot_open;
        rd_en               = req_xfer;
      end
      default: begin
        s1_next.is_open = slot_open;
      end
    endcase
  end

  hta_ram #(
    .WIDTH (hta_pkg::HANDLE_W),
    .DEPTH (TABLE_SIZE)
  ) u_handle_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(free_idx)),
    .wr_data (host_handle),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (ram_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      open_map    <= MAP_RESET;
      preset_live <= '1;
    end else if (req_xfer) begin
      if (opcode == hta_pkg::OP_OPEN && free_found) begin
        open_map[free_idx] <= 1'b1;
        // A preset slot that is opened again now holds its handle in the RAM.
        if ({1'b0, free_idx} < (MW + 1)'(hta_pkg::PRESET_SLOTS)) begin
          preset_live[free_idx[PW-1:0]] <= 1'b0;
        end
      end else if (opcode == hta_pkg::OP_CLOSE && slot_open) begin
        open_map[slot[MW-1:0]] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_xfer) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
    if (req_xfer) begin
      s1 <= s1_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s1_adv) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
    if (s1_adv) begin
      ok       <= s1.ok;
      slot_out <= s1.slot;
      is_open  <= s1.is_open;
      if (!s1.want_handle) begin
        handle_out <= '0;
      end else if (s1.use_preset) begin
        handle_out <= hta_pkg::HANDLE_W'(s1.preset_val);
      end else begin
        handle_out <= ram_data;
      end
    end
  end

endmodule

/* src/hta_checker.sv */
// ----------------------------------------------------------------------------
// hta_checker
// Port-level checks for the handle table allocator, bound to the top level.
// ----------------------------------------------------------------------------
module hta_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         req_stall,
  input logic                         rsp_valid,
  input logic                         rsp_stall,
  input logic                         ok,
  input logic [hta_pkg::HANDLE_W-1:0] handle_out
);

  // A response that is not taken stays offered.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid)
    else $error("response dropped while stalled");

  // Requests are held back only when the response side is backed up.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> rsp_valid && rsp_stall)
    else $error("request stalled without a stalled response");

  // A failed request never returns a handle.
  a_fail_handle: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !ok |-> handle_out == '0)
    else $error("handle returned on a failed request");

  // Nothing is offered in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !rsp_valid)
    else $error("response valid right after reset");

endmodule

bind handle_table_allocator hta_checker u_hta_checker (
  .clk        (clk),
  .rst        (rst),
  .req_stall  (req_stall),
  .rsp_valid  (rsp_valid),
  .rsp_stall  (rsp_stall),
  .ok         (ok),
  .handle_out (handle_out)
);

/* sim/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Handle table allocator testbench
// Sends open, close, lookup and unused-opcode requests over the request
// channel. A local copy of the slot table gives the expected response of every
// request, and each response transfer is checked in order, field by field.
// Both channels idle at random, and the response side is held off for a long
// stretch so that the block fills up and stalls its input.
// ----------------------------------------------------------------------------
module testbench;

  localparam int OP_W        = hta_pkg::OP_W;
  localparam int SLOT_W      = hta_pkg::SLOT_W;
  localparam int HANDLE_W    = hta_pkg::HANDLE_W;
  localparam logic [OP_W-1:0] OP_OPEN   = hta_pkg::OP_OPEN;
  localparam logic [OP_W-1:0] OP_CLOSE  = hta_pkg::OP_CLOSE;
  localparam logic [OP_W-1:0] OP_LOOKUP = hta_pkg::OP_LOOKUP;
  localparam int TBL         = hta_pkg::TABLE_SIZE_DEF;
  localparam int SEARCH_LEN  = (TBL < hta_pkg::SLOT_SPACE) ? TBL : hta_pkg::SLOT_SPACE;
  localparam logic [OP_W-1:0] OP_NONE = 2'd3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_LEN    = 60;
  localparam int TAIL_CYCLES = 6;

  typedef struct packed {
    logic                ok;
    logic [SLOT_W-1:0]   slot;
    logic [HANDLE_W-1:0] handle;
    logic                occ;
  } table_rsp_t;

  logic clk = 1'b0;
  logic rst;

  logic                req_valid;
  logic                req_stall;
  logic [OP_W-1:0]     opcode;
  logic [SLOT_W-1:0]   slot;
  logic [HANDLE_W-1:0] host_handle;

  logic                rsp_valid;
  logic                rsp_stall = 1'b0;
  logic                ok;
  logic [SLOT_W-1:0]   slot_out;
  logic [HANDLE_W-1:0] handle_out;
  logic                is_open;

  // Local copy of the table.
  bit                  slot_open   [TBL];
  logic [HANDLE_W-1:0] slot_handle [TBL];

  table_rsp_t pending_rsp_q[$];

  int  req_sent       = 0;
  int  rsp_seen       = 0;
  int  mismatch_cnt   = 0;
  int  cycle_cnt      = 0;
  int  send_idle_pct  = 0;
  int  recv_idle_pct  = 0;
  logic rsp_hold      = 1'b0;
  bit  fill_mode      = 1'b1;

  int  opens_granted  = 0;
  int  opens_refused  = 0;
  int  closes_done    = 0;
  int  closes_refused = 0;
  int  lookups_done   = 0;
  int  noops_done     = 0;

  handle_table_allocator #(
    .TABLE_SIZE (TBL)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .opcode      (opcode),
    .slot        (slot),
    .host_handle (host_handle),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .ok          (ok),
    .slot_out    (slot_out),
    .handle_out  (handle_out),
    .is_open     (is_open)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d of %0d responses seen",
               cycle_cnt, rsp_seen, req_sent);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver: random stalls, overridden by a long hold-off when requested.
  always @(posedge clk) begin
    if (rsp_hold) begin
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_cnt, msg);
    mismatch_cnt++;
  endtask

  function automatic bit slot_is_open(input logic [SLOT_W-1:0] s);
    if (int'(s) >= TBL) return 1'b0;
    return slot_open[s];
  endfunction

  // Applies one request to the local table and returns the response it gives.
  function automatic table_rsp_t apply_request(input logic [OP_W-1:0] op,
                                               input logic [SLOT_W-1:0] s,
                                               input logic [HANDLE_W-1:0] h);
    table_rsp_t r;
    bit         found;
    r      = '0;
    r.slot = s;
    found  = 1'b0;
    case (op)
      OP_OPEN: begin
        r.slot = '0;
        for (int i = 0; i < SEARCH_LEN; i++) begin
          if (!found && !slot_open[i]) begin
            found          = 1'b1;
            slot_open[i]   = 1'b1;
            slot_handle[i] = h;
            r.ok           = 1'b1;
            r.slot         = SLOT_W'(i);
            r.occ          = 1'b1;
          end
        end
        if (found) opens_granted++;
        else opens_refused++;
      end
      OP_CLOSE: begin
        if (slot_is_open(s)) begin
          r.handle     = slot_handle[s];
          r.ok         = 1'b1;
          slot_open[s] = 1'b0;
          closes_done++;
        end else begin
          closes_refused++;
        end
      end
      OP_LOOKUP: begin
        if (slot_is_open(s)) begin
          r.handle = slot_handle[s];
          r.ok     = 1'b1;
          r.occ    = 1'b1;
        end
        lookups_done++;
      end
      default: begin
        r.occ = slot_is_open(s);
        noops_done++;
      end
    endcase
    return r;
  endfunction

  function automatic int open_count();
    int n;
    n = 0;
    for (int i = 0; i < TBL; i++) n += slot_open[i];
    return n;
  endfunction

  // Sends one request and returns at the edge where its transfer happens.
  task automatic send_req(input logic [OP_W-1:0] op, input logic [SLOT_W-1:0] s,
                          input logic [HANDLE_W-1:0] h);
    pending_rsp_q.push_back(apply_request(op, s, h));
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid   <= 1'b1;
    opcode      <= op;
    slot        <= s;
    host_handle <= h;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    req_sent++;
  endtask

  task automatic wait_for_drain();
    req_valid <= 1'b0;
    while (rsp_seen < req_sent) @(posedge clk);
  endtask

  always @(posedge clk) begin
    table_rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_rsp_q.size() == 0) begin
        report_mismatch($sformatf("response with nothing pending (slot_out %0d)",
                                  slot_out));
      end else begin
        want = pending_rsp_q.pop_front();
        if (ok !== want.ok)
          report_mismatch($sformatf("ok got %b want %b", ok, want.ok));
        if (slot_out !== want.slot)
          report_mismatch($sformatf("slot_out got %0d want %0d", slot_out, want.slot));
        if (handle_out !== want.handle)
          report_mismatch($sformatf("handle_out got %h want %h", handle_out,
                                    want.handle));
        if (is_open !== want.occ)
          report_mismatch($sformatf("is_open got %b want %b", is_open, want.occ));
      end
      rsp_seen++;
    end
  end

  // One request of the random mix. The mix leans toward opening or closing
  // and flips over near full and near empty, so the table swings end to end.
  task automatic send_random_request();
    int                  n_open;
    int                  pick;
    int                  r;
    logic [OP_W-1:0]     op;
    logic [SLOT_W-1:0]   s;
    n_open = open_count();
    if (n_open >= SEARCH_LEN && $urandom_range(3) == 0) fill_mode = 1'b0;
    if (n_open <= 2 && $urandom_range(3) == 0) fill_mode = 1'b1;
    r = $urandom_range(99);
    if (r < 5) op = OP_NONE;
    else if (r < 25) op = OP_LOOKUP;
    else if (r < (fill_mode ? 80 : 45)) op = OP_OPEN;
    else op = OP_CLOSE;
    s = SLOT_W'($urandom());
    if (op != OP_OPEN && n_open > 0 && $urandom_range(9) < 8) begin
      pick = $urandom_range(n_open - 1);
      for (int i = 0; i < TBL; i++) begin
        if (slot_open[i]) begin
          if (pick == 0) s = SLOT_W'(i);
          pick--;
        end
      end
    end
    send_req(op, s, HANDLE_W'($urandom()));
  endtask

  task automatic test_directed();
    send_req(OP_LOOKUP, 5'd0, 16'h1234);
    send_req(OP_LOOKUP, 5'd1, 16'h0000);
    send_req(OP_LOOKUP, 5'd2, 16'hFFFF);
    send_req(OP_LOOKUP, 5'd31, 16'h0000);
    send_req(OP_CLOSE, 5'd31, 16'hFFFF);
    send_req(OP_NONE, 5'd0, 16'hFFFF);
    send_req(OP_NONE, 5'd31, 16'h0000);
    send_req(OP_OPEN, 5'd31, 16'hFFFF);
    send_req(OP_OPEN, 5'd0, 16'h0000);
    send_req(OP_OPEN, 5'd17, 16'hA5A5);
    send_req(OP_LOOKUP, 5'd3, 16'h0000);
    send_req(OP_LOOKUP, 5'd4, 16'h0000);
    send_req(OP_CLOSE, 5'd1, 16'h0000);
    send_req(OP_LOOKUP, 5'd1, 16'h0000);
    send_req(OP_CLOSE, 5'd1, 16'h0000);
    // The lowest free slot is now the one just closed.
    send_req(OP_OPEN, 5'd0, 16'h5A5A);
    send_req(OP_CLOSE, 5'd1, 16'h0000);
    send_req(OP_CLOSE, 5'd0, 16'h0000);
    send_req(OP_NONE, 5'd0, 16'h0000);
    send_req(OP_OPEN, 5'd0, 16'h8001);
    send_req(OP_CLOSE, 5'd5, 16'h0000);
    wait_for_drain();
  endtask

  task automatic test_table_full();
    while (open_count() < SEARCH_LEN) send_req(OP_OPEN, SLOT_W'($urandom()),
                                               HANDLE_W'($urandom()));
    send_req(OP_OPEN, 5'd0, 16'hFFFF);
    send_req(OP_OPEN, 5'd31, 16'h0000);
    send_req(OP_LOOKUP, 5'd31, 16'h0000);
    send_req(OP_CLOSE, 5'd31, 16'h0000);
    send_req(OP_NONE, 5'd31, 16'h0000);
    send_req(OP_OPEN, 5'd7, 16'hC3C3);
    send_req(OP_CLOSE, 5'd0, 16'h0000);
    send_req(OP_CLOSE, 5'd16, 16'h0000);
    send_req(OP_OPEN, 5'd0, 16'h0F0F);
    send_req(OP_OPEN, 5'd0, 16'hF0F0);
    send_req(OP_OPEN, 5'd0, 16'h0001);
    wait_for_drain();
    fill_mode = 1'b0;
  endtask

  task automatic test_random_traffic(input int n, input int send_pct,
                                     input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (n) send_random_request();
    wait_for_drain();
  endtask

  // The receiver is held off while the sender keeps offering requests, so
  // the pipeline fills and the request side must stall.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    fork
      begin
        rsp_hold <= 1'b1;
        repeat (HOLD_LEN) @(posedge clk);
        rsp_hold <= 1'b0;
      end
    join_none
    repeat (24) send_random_request();
    wait_for_drain();
    send_random_request();
    wait_for_drain();
  endtask

  initial begin
    rst         <= 1'b1;
    req_valid   <= 1'b0;
    opcode      <= OP_LOOKUP;
    slot        <= '0;
    host_handle <= '0;
    for (int i = 0; i < TBL; i++) begin
      slot_open[i]   = (i < hta_pkg::PRESET_SLOTS);
      slot_handle[i] = HANDLE_W'(i);
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_table_full();
    test_random_traffic(270, 33, 80);
    test_random_traffic(270, 80, 33);
    test_backpressure();
    test_random_traffic(280, 0, 0);

    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_rsp_q.size() != 0)
      report_mismatch($sformatf("%0d responses never arrived", pending_rsp_q.size()));

    $display("%0d requests: %0d opens granted, %0d refused on a full table, %0d closes",
             req_sent, opens_granted, opens_refused, closes_done);
    $display("%0d closes of free slots, %0d lookups, %0d unused opcodes, %0d mismatches",
             closes_refused, lookups_done, noops_done, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/hta_pkg.sv
src/hta_ram.sv
src/handle_table_allocator.sv
src/hta_checker.sv
sim/testbench.sv
